FILE: hw/rtl/bia_pkg.sv
package bia_pkg;

    localparam int MAP_WORDS_DEF = 32;
    localparam int WORD_W        = 32;
    localparam int BIT_W         = 5;
    localparam int ID_W          = 11;
    localparam int STAT_W        = 2;

    localparam logic [WORD_W-1:0] FULL_WORD = 32'hffff_ffff;
    localparam logic [BIT_W-1:0]  BIT_MASK  = 5'h1f;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_BAD_ID = 2'd2
    } t_status;

    typedef struct packed {
        logic vld;
        logic full;
    } t_nf_upd;

    function automatic logic [BIT_W-1:0] lowest_clear_bit(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] b;
        b = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                b = BIT_W'(i);
            end
        end
        return b;
    endfunction

endpackage

FILE: hw/rtl/bia_req_if.sv
interface bia_req_if;
    import bia_pkg::*;

    logic             valid;
    logic             ready;
    logic             cmd;
    logic [ID_W-1:0]  free_id;

    modport source (output valid, output cmd, output free_id, input ready);
    modport sink   (input valid, input cmd, input free_id, output ready);
endinterface

FILE: hw/rtl/bia_rsp_if.sv
interface bia_rsp_if;
    import bia_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   new_id;
    logic [STAT_W-1:0] status;

    modport source (output valid, output new_id, output status, input ready);
    modport sink   (input valid, input new_id, input status, output ready);
endinterface

FILE: hw/rtl/bia_ram.sv
module bia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/bia_nf_map.sv
module bia_nf_map #(
    parameter int MAP_WORDS = bia_pkg::MAP_WORDS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  bia_pkg::t_nf_upd                             i_upd,
    input  logic [(MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1)-1:0] i_upd_idx,
    output logic                                         o_found,
    output logic [(MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1)-1:0] o_first
);
    import bia_pkg::*;

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [MAP_WORDS-1:0] r_nf;
    logic [MAP_WORDS-1:0] n_nf;
    logic [AW-1:0]        first;

    always_comb begin
        n_nf = r_nf;
        if (i_upd.vld) begin
            n_nf[i_upd_idx] = !i_upd.full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nf <= '1;
        end else begin
            r_nf <= n_nf;
        end
    end

    always_comb begin
        first = '0;
        for (int i = MAP_WORDS - 1; i >= 0; i--) begin
            if (r_nf[i]) begin
                first = AW'(i);
            end
        end
    end

    assign o_found = |r_nf;
    assign o_first = first;
endmodule

FILE: hw/rtl/bitmap_id_allocator_top.sv
// An accepted word is read from one bitmap memory entry into a register; its answer
// is registered onto the result port once that port is free. A new word is not taken
// until the last one's read-modify-write (a read, then a write-back) is through.
// Reset: synchronous, active low; afterwards a clearing pass writes zeros to each of
// the MAP_WORDS bitmap memory entries, during which no request is taken.
module bitmap_id_allocator_top #(
    parameter int MAP_WORDS = bia_pkg::MAP_WORDS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bia_req_if.sink         i_req,
    bia_rsp_if.source       o_rsp
);
    import bia_pkg::*;

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_MOD   = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0]     r_clr_idx, n_clr_idx;
    logic              r_cmd, n_cmd;
    logic [AW-1:0]     r_word, n_word;
    logic              r_found, n_found;
    logic              r_bad, n_bad;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic              r_out_vld, n_out_vld;
    logic [ID_W-1:0]   r_new_id, n_new_id;
    logic [STAT_W-1:0] r_status, n_status;

    logic              accept;
    logic              out_free;
    logic              load;
    logic              nf_found;
    logic [AW-1:0]     nf_first;
    t_nf_upd           nf_upd;
    logic [AW-1:0]     nf_upd_idx;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [ID_W-1:0]   fid_bit;
    logic [31:0]       fid_word32;
    logic [AW-1:0]     fid_word;
    logic              fid_bad;
    logic [BIT_W-1:0]  clr_bit;
    logic [WORD_W-1:0] alloc_word;
    logic [WORD_W-1:0] free_word;
    logic [31:0]       id32;

    bia_nf_map #(.MAP_WORDS(MAP_WORDS)) u_nf_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (nf_upd),
        .i_upd_idx (nf_upd_idx),
        .o_found   (nf_found),
        .o_first   (nf_first)
    );

    bia_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_vld || o_rsp.ready;
    assign load        = (r_state == ST_MOD) && out_free;

    assign fid_bit    = i_req.free_id - ID_W'(1);
    assign fid_word32 = 32'(fid_bit) >> BIT_W;
    assign fid_word   = fid_word32[AW-1:0];
    assign fid_bad    = (i_req.free_id == '0)
                     || (32'(i_req.free_id) > 32'(MAP_WORDS) * 32'(WORD_W));

    assign ram_re    = accept;
    assign ram_raddr = (i_req.cmd == CMD_ALLOC) ? nf_first : fid_word;

    assign clr_bit    = lowest_clear_bit(ram_rdata);
    assign alloc_word = ram_rdata | (WORD_W'(1) << clr_bit);
    assign free_word  = ram_rdata & ~(WORD_W'(1) << (r_bit & BIT_MASK));
    assign id32       = (32'(r_word) << BIT_W) + 32'(clr_bit) + 32'd1;

    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = r_word;
        ram_wdata  = '0;
        nf_upd     = '0;
        nf_upd_idx = r_word;
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_idx;
        end else if (load) begin
            if (r_cmd == CMD_ALLOC) begin
                ram_we      = r_found;
                ram_wdata   = alloc_word;
                nf_upd.vld  = r_found;
                nf_upd.full = (alloc_word == FULL_WORD);
            end else begin
                ram_we      = !r_bad;
                ram_wdata   = free_word;
                nf_upd.vld  = !r_bad;
                nf_upd.full = 1'b0;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_cmd     = r_cmd;
        n_word    = r_word;
        n_found   = r_found;
        n_bad     = r_bad;
        n_bit     = r_bit;
        n_new_id  = r_new_id;
        n_status  = r_status;
        n_out_vld = r_out_vld && !o_rsp.ready;
        case (r_state)
            ST_CLEAR: begin
                n_clr_idx = r_clr_idx + AW'(1);
                if (32'(r_clr_idx) == 32'(MAP_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_cmd   = i_req.cmd;
                    n_found = nf_found;
                    n_bad   = fid_bad;
                    n_bit   = fid_bit[BIT_W-1:0];
                    n_word  = (i_req.cmd == CMD_ALLOC) ? nf_first : fid_word;
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_new_id  = '0;
                    n_status  = STAT_OK;
                    if (r_cmd == CMD_ALLOC) begin
                        if (r_found) begin
                            n_new_id = id32[ID_W-1:0];
                        end else begin
                            n_status = STAT_FULL;
                        end
                    end else if (r_bad) begin
                        n_status = STAT_BAD_ID;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_word   <= n_word;
        r_found  <= n_found;
        r_bad    <= n_bad;
        r_bit    <= n_bit;
        r_new_id <= n_new_id;
        r_status <= n_status;
    end

    assign o_rsp.valid  = r_out_vld;
    assign o_rsp.new_id = r_new_id;
    assign o_rsp.status = r_status;
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bia_pkg::*;

    localparam int N_WORDS = MAP_WORDS_DEF;
    localparam int N_IDS   = N_WORDS * WORD_W;
    localparam int N_DIR   = 20;

    typedef struct packed {
        logic [ID_W-1:0] nid;
        t_status         st;
    } t_reply;

    typedef struct packed {
        t_cmd            cmd;
        logic [ID_W-1:0] fid;
        logic            typed;
        logic [ID_W-1:0] nid;
        t_status         st;
    } t_dir_row;

    logic clk;
    logic rst_n;

    bia_req_if req_if ();
    bia_rsp_if rsp_if ();

    bitmap_id_allocator_top #(
        .MAP_WORDS (N_WORDS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    logic [WORD_W-1:0] id_map [N_WORDS];
    int                ids_in_use;
    t_reply            replies_due [$];
    int                mismatches;
    int                send_idle_pct;
    int                rsp_idle_pct;
    int                hold_cycles;

    t_dir_row dir_rows [N_DIR] = '{
        '{CMD_ALLOC, 11'd0,    1'b1, 11'd1, STAT_OK},
        '{CMD_ALLOC, 11'd2047, 1'b1, 11'd2, STAT_OK},
        '{CMD_ALLOC, 11'd0,    1'b1, 11'd3, STAT_OK},
        '{CMD_FREE,  11'd0,    1'b1, 11'd0, STAT_BAD_ID},
        '{CMD_FREE,  11'd1025, 1'b1, 11'd0, STAT_BAD_ID},
        '{CMD_FREE,  11'd2047, 1'b1, 11'd0, STAT_BAD_ID},
        '{CMD_FREE,  11'd1024, 1'b1, 11'd0, STAT_OK},
        '{CMD_FREE,  11'd2,    1'b1, 11'd0, STAT_OK},
        '{CMD_FREE,  11'd2,    1'b1, 11'd0, STAT_OK},
        '{CMD_ALLOC, 11'd0,    1'b0, 11'd0, STAT_OK},
        '{CMD_FREE,  11'd1,    1'b1, 11'd0, STAT_OK},
        '{CMD_ALLOC, 11'd1365, 1'b0, 11'd0, STAT_OK},
        '{CMD_ALLOC, 11'd682,  1'b0, 11'd0, STAT_OK},
        '{CMD_FREE,  11'd1365, 1'b1, 11'd0, STAT_BAD_ID},
        '{CMD_FREE,  11'd682,  1'b1, 11'd0, STAT_OK},
        '{CMD_FREE,  11'd3,    1'b1, 11'd0, STAT_OK},
        '{CMD_ALLOC, 11'd0,    1'b0, 11'd0, STAT_OK},
        '{CMD_ALLOC, 11'd0,    1'b0, 11'd0, STAT_OK},
        '{CMD_FREE,  11'd32,   1'b1, 11'd0, STAT_OK},
        '{CMD_ALLOC, 11'd0,    1'b0, 11'd0, STAT_OK}
    };

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic apply_to_id_map(input t_cmd c, input logic [ID_W-1:0] fid,
                                   output logic [ID_W-1:0] nid, output t_status st);
        int b;
        int idx;
        nid = '0;
        st  = STAT_OK;
        if (c == CMD_ALLOC) begin
            st = STAT_FULL;
            for (int w = 0; w < N_WORDS; w++) begin
                if (id_map[w] != FULL_WORD) begin
                    b = 0;
                    while (id_map[w][b]) b++;
                    id_map[w][b] = 1'b1;
                    nid = ID_W'(w * WORD_W + b + 1);
                    st = STAT_OK;
                    ids_in_use++;
                    break;
                end
            end
        end else if (fid == 0 || int'(fid) > N_IDS) begin
            st = STAT_BAD_ID;
        end else begin
            idx = int'(fid) - 1;
            if (id_map[idx >> BIT_W][idx & int'(BIT_MASK)]) begin
                ids_in_use--;
            end
            id_map[idx >> BIT_W][idx & int'(BIT_MASK)] = 1'b0;
        end
    endtask

    function automatic logic [ID_W-1:0] some_used_id();
        int cand;
        do begin
            cand = $urandom_range(N_IDS, 1);
        end while (!id_map[(cand - 1) >> BIT_W][(cand - 1) & int'(BIT_MASK)]);
        return ID_W'(cand);
    endfunction

    task automatic send_word(input t_cmd c, input logic [ID_W-1:0] fid, input logic typed,
                             input logic [ID_W-1:0] t_nid, input t_status t_st);
        t_reply r;
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.cmd     <= c;
        req_if.free_id <= fid;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        apply_to_id_map(c, fid, r.nid, r.st);
        if (typed) begin
            r.nid = t_nid;
            r.st  = t_st;
        end
        replies_due.push_back(r);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (replies_due.size() != 0);
    endtask

    task automatic run_phase(input int n, input int s_idle, input int r_idle,
                             input int alloc_pct, input bit long_hold);
        t_cmd            c;
        logic [ID_W-1:0] fid;
        int              r;
        send_idle_pct = s_idle;
        rsp_idle_pct  = r_idle;
        if (long_hold) hold_cycles = 400;
        repeat (n) begin
            c = ($urandom_range(99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
            r = $urandom_range(99);
            if (c == CMD_ALLOC || r >= 85) begin
                fid = ID_W'($urandom);
            end else if (r < 70 && ids_in_use > 0) begin
                fid = some_used_id();
            end else begin
                fid = ID_W'($urandom_range(N_IDS, 1));
            end
            send_word(c, fid, 1'b0, '0, STAT_OK);
        end
        req_if.valid <= 1'b0;
        wait_drained();
    endtask

    initial begin
        t_reply exp;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready) begin
                if (replies_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: reply with none due: new_id %0d status %0d",
                             $time, rsp_if.new_id, rsp_if.status);
                end else begin
                    exp = replies_due.pop_front();
                    if (rsp_if.new_id !== exp.nid) begin
                        mismatches++;
                        $display("%0t: new_id expected %0d actual %0d",
                                 $time, exp.nid, rsp_if.new_id);
                    end
                    if (rsp_if.status !== exp.st) begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp.st, rsp_if.status);
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("bitmap_id_allocator_top test failed");
        $finish;
    end

    initial begin
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.cmd     = CMD_ALLOC;
        req_if.free_id = '0;
        mismatches     = 0;
        ids_in_use     = 0;
        hold_cycles    = 0;
        send_idle_pct  = 31;
        rsp_idle_pct   = 82;
        for (int w = 0; w < N_WORDS; w++) id_map[w] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            send_word(dir_rows[i].cmd, dir_rows[i].fid, dir_rows[i].typed,
                      dir_rows[i].nid, dir_rows[i].st);
        end
        req_if.valid <= 1'b0;
        wait_drained();

        run_phase(620, 31, 82, 95, 1'b0);
        run_phase(620, 82, 31, 95, 1'b0);
        run_phase(600, 0, 0, 45, 1'b1);

        repeat (10) @(posedge clk);
        if (mismatches == 0) begin
            $display("bitmap_id_allocator_top test passed");
        end else begin
            $display("bitmap_id_allocator_top test failed");
        end
        $finish;
    end

endmodule
